FILE: hdl/wpps_pkg.sv
// Shared types, constants and the wave table of the waving pattern pixel shader.
`default_nettype none

package wpps_pkg;

    // Matrix size defaults
    localparam int WIDTH_DEF  = 8;
    localparam int HEIGHT_DEF = 16;

    // Wave table length and register defaults
    localparam int WAVE_LEN = 50;
    localparam logic [5:0]  WAVE_STEP_RST  = 6'd3;
    localparam logic [5:0]  WAVE_START_RST = 6'd40;
    localparam logic [23:0] COLOR_ZERO_RST = 24'h000000;
    localparam logic [23:0] COLOR_ONE_RST  = 24'hC0C0C0;
    localparam logic [23:0] COLOR_TWO_RST  = 24'hFF0000;

    // Port widths
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [1:0] {
        OP_RENDER  = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_LOAD    = 2'd2,
        OP_RESTART = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVE_STEP  = 3'd0,
        CFG_WAVE_START = 3'd1,
        CFG_COLOR_ZERO = 3'd2,
        CFG_COLOR_ONE  = 3'd3,
        CFG_COLOR_TWO  = 3'd4
    } cfg_index_t;

    // Palette indexes
    localparam logic [1:0] PAL_ZERO = 2'd0;
    localparam logic [1:0] PAL_ONE  = 2'd1;
    localparam logic [1:0] PAL_TWO  = 2'd2;

    function automatic logic signed [7:0] sine_lookup(input logic [5:0] idx);
        logic signed [7:0] v;
        case (idx)
            6'd0:  v = 8'sd16;    6'd1:  v = 8'sd32;    6'd2:  v = 8'sd47;
            6'd3:  v = 8'sd61;    6'd4:  v = 8'sd75;    6'd5:  v = 8'sd87;
            6'd6:  v = 8'sd98;    6'd7:  v = 8'sd107;   6'd8:  v = 8'sd115;
            6'd9:  v = 8'sd121;   6'd10: v = 8'sd125;   6'd11: v = 8'sd127;
            6'd12: v = 8'sd127;   6'd13: v = 8'sd125;   6'd14: v = 8'sd121;
            6'd15: v = 8'sd115;   6'd16: v = 8'sd107;   6'd17: v = 8'sd98;
            6'd18: v = 8'sd87;    6'd19: v = 8'sd75;    6'd20: v = 8'sd61;
            6'd21: v = 8'sd47;    6'd22: v = 8'sd32;    6'd23: v = 8'sd16;
            6'd24: v = 8'sd0;     6'd25: v = -8'sd16;   6'd26: v = -8'sd32;
            6'd27: v = -8'sd47;   6'd28: v = -8'sd61;   6'd29: v = -8'sd75;
            6'd30: v = -8'sd87;   6'd31: v = -8'sd98;   6'd32: v = -8'sd107;
            6'd33: v = -8'sd115;  6'd34: v = -8'sd121;  6'd35: v = -8'sd125;
            6'd36: v = -8'sd127;  6'd37: v = -8'sd127;  6'd38: v = -8'sd125;
            6'd39: v = -8'sd121;  6'd40: v = -8'sd115;  6'd41: v = -8'sd107;
            6'd42: v = -8'sd98;   6'd43: v = -8'sd87;   6'd44: v = -8'sd75;
            6'd45: v = -8'sd61;   6'd46: v = -8'sd47;   6'd47: v = -8'sd32;
            6'd48: v = -8'sd16;   6'd49: v = 8'sd0;
            default: v = 8'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/wpps_blend.sv
// One color channel blend: a + mix * (b - a) / 255, truncating toward zero.
`default_nettype none

module wpps_blend
(
    input  wire logic [7:0] upper,
    input  wire logic [7:0] lower,
    input  wire logic [7:0] mix,
    output logic [7:0]      result
);
    logic        rising;
    logic [7:0]  mag;
    logic [15:0] prod;
    logic [16:0] sum;
    logic [7:0]  quot;

    always_comb
    begin
        rising = (lower >= upper);
        mag    = rising ? (lower - upper) : (upper - lower);
        prod   = 16'(mag) * 16'(mix);
        // exact floor of prod / 255 for prod below 255 * 256
        sum    = 17'(prod) + 17'(prod[15:8]) + 17'd1;
        quot   = sum[15:8];
        result = rising ? (upper + quot) : (upper - quot);
    end

endmodule

`default_nettype wire

FILE: hdl/waving_pattern_pixel_shader_top.sv
// Waving pattern pixel shader: input register, wave and store read stage, blend and output.
// A render item passes the input register, then the stage 2 and store read registers, and
// then the output register.
// Throughput: one item per cycle; a stage holds only while the output register is full and
// not taken, and empty stages still take items.
// Reset (rst_n low, asynchronous): clears all valid flags, sets the phase to 40 and the
// registers to their defaults; the pattern store keeps its contents and is not cleared.
`default_nettype none

module waving_pattern_pixel_shader_top
#(
    parameter int WIDTH  = wpps_pkg::WIDTH_DEF,
    parameter int HEIGHT = wpps_pkg::HEIGHT_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // column [2:0], line [6:3], cell_index [8:7], zero fill above
    input  wire logic [wpps_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode [1:0]
    input  wire logic [wpps_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // red [7:0], green [15:8], blue [23:16], out_column [26:24], out_line [30:27]
    output logic [wpps_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                             cfg_we,
    input  wire logic [wpps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wpps_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wpps_pkg::*;

    localparam int CELLS = WIDTH * HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] ROW_STEP = AW'(WIDTH);

    function automatic logic [5:0] add_mod(input logic [5:0] a, input logic [5:0] b);
        logic [6:0] sum;
        sum = 7'(a) + 7'(b);
        return (sum >= 7'(WAVE_LEN)) ? 6'(sum - 7'(WAVE_LEN)) : sum[5:0];
    endfunction

    // Configuration; the wave step is kept as step, 2*step and 4*step, all mod 50
    logic [5:0]  step1_reg, step2_reg, step4_reg;
    logic [5:0]  start_reg;
    logic [23:0] color_zero_reg, color_one_reg, color_two_reg;
    logic [5:0]  cfg_s1, cfg_s2;

    always_comb
    begin
        cfg_s1 = add_mod(cfg_data[5:0], 6'd0);
        cfg_s2 = add_mod(cfg_s1, cfg_s1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step1_reg      <= WAVE_STEP_RST;
            step2_reg      <= add_mod(WAVE_STEP_RST, WAVE_STEP_RST);
            step4_reg      <= add_mod(add_mod(WAVE_STEP_RST, WAVE_STEP_RST),
                                      add_mod(WAVE_STEP_RST, WAVE_STEP_RST));
            start_reg      <= WAVE_START_RST;
            color_zero_reg <= COLOR_ZERO_RST;
            color_one_reg  <= COLOR_ONE_RST;
            color_two_reg  <= COLOR_TWO_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WAVE_STEP:
                begin
                    step1_reg <= cfg_s1;
                    step2_reg <= cfg_s2;
                    step4_reg <= add_mod(cfg_s2, cfg_s2);
                end
                CFG_WAVE_START: start_reg      <= add_mod(cfg_data[5:0], 6'd0);
                CFG_COLOR_ZERO: color_zero_reg <= cfg_data;
                CFG_COLOR_ONE:  color_one_reg  <= cfg_data;
                CFG_COLOR_TWO:  color_two_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advance, from the output back
    logic out_v_reg, s2_v_reg, s1_v_reg;
    logic en_out, en2, en1;

    always_comb
    begin
        en_out = !out_v_reg || m_axis_tready;
        en2    = !s2_v_reg || en_out;
        en1    = !s1_v_reg || en2;
    end

    assign s_axis_tready = en1;

    // Input register
    opcode_t    s1_op_reg;
    logic [2:0] s1_col_reg;
    logic [3:0] s1_line_reg;
    logic [1:0] s1_cidx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en1)
            s1_v_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en1 && s_axis_tvalid)
        begin
            s1_op_reg   <= opcode_t'(s_axis_tuser[1:0]);
            s1_col_reg  <= s_axis_tdata[2:0];
            s1_line_reg <= s_axis_tdata[6:3];
            s1_cidx_reg <= s_axis_tdata[8:7];
        end
    end

    // Stage 1: wave index, row choice and store addresses
    logic [5:0]        phase_reg, phase_next;
    logic [5:0]        t0, t1, t2;
    logic signed [7:0] sine_val;
    logic signed [8:0] d_val, neg_mix;
    logic              pos, on, up_ok, lo_ok;
    logic [7:0]        mix_val;
    logic [AW-1:0]     base_addr, up_addr, lo_addr;
    logic              s1_move;

    always_comb
    begin
        on        = (32'(s1_col_reg) < WIDTH) && (32'(s1_line_reg) < HEIGHT);
        base_addr = AW'(32'(s1_line_reg) * WIDTH + 32'(s1_col_reg));
        t0        = s1_col_reg[0] ? add_mod(phase_reg, step1_reg) : phase_reg;
        t1        = s1_col_reg[1] ? add_mod(t0, step2_reg) : t0;
        t2        = s1_col_reg[2] ? add_mod(t1, step4_reg) : t1;
        sine_val  = sine_lookup(t2);
        d_val     = {sine_val, 1'b0};
        pos       = !d_val[8] && (d_val != 9'sd0);
        neg_mix   = 9'sd255 + d_val;
        mix_val   = pos ? d_val[7:0] : neg_mix[7:0];
        // upper row is the pixel row where the wave value is positive, the row above otherwise
        up_ok     = pos || (s1_line_reg != 4'd0);
        lo_ok     = !pos || (32'(s1_line_reg) + 1 < HEIGHT);
        up_addr   = (!pos && up_ok) ? (base_addr - ROW_STEP) : base_addr;
        lo_addr   = (pos && lo_ok) ? (base_addr + ROW_STEP) : base_addr;
        s1_move   = en2 && s1_v_reg;
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (s1_move)
        begin
            case (s1_op_reg)
                OP_ADVANCE: phase_next = add_mod(phase_reg, 6'd1);
                OP_RESTART: phase_next = start_reg;
                default:    phase_next = phase_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= WAVE_START_RST;
        else
            phase_reg <= phase_next;
    end

    // Pattern store: one write port, two registered read ports
    logic [1:0] store_mem [CELLS];
    logic [1:0] rd_up_reg, rd_lo_reg;

    always_ff @(posedge clk)
    begin
        if (s1_move && (s1_op_reg == OP_LOAD) && on)
            store_mem[base_addr] <= s1_cidx_reg;
        if (en2)
        begin
            rd_up_reg <= store_mem[up_addr];
            rd_lo_reg <= store_mem[lo_addr];
        end
    end

    // Stage 2 register
    logic [7:0] s2_mix_reg;
    logic       s2_up_ok_reg, s2_lo_ok_reg;
    logic [2:0] s2_col_reg;
    logic [3:0] s2_line_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (en2)
            s2_v_reg <= s1_v_reg && (s1_op_reg == OP_RENDER) && on;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_mix_reg   <= mix_val;
            s2_up_ok_reg <= up_ok;
            s2_lo_ok_reg <= lo_ok;
            s2_col_reg   <= s1_col_reg;
            s2_line_reg  <= s1_line_reg;
        end
    end

    // Stage 2: palette and blend
    function automatic logic [23:0] palette(input logic [1:0] idx, input logic [23:0] c0,
                                            input logic [23:0] c1, input logic [23:0] c2);
        logic [23:0] c;
        case (idx)
            PAL_ZERO: c = c0;
            PAL_ONE:  c = c1;
            PAL_TWO:  c = c2;
            default:  c = 24'h000000;
        endcase
        return c;
    endfunction

    logic [23:0] up_color, lo_color;
    logic [7:0]  red, green, blue;

    always_comb
    begin
        up_color = s2_up_ok_reg
                 ? palette(rd_up_reg, color_zero_reg, color_one_reg, color_two_reg) : 24'h0;
        lo_color = s2_lo_ok_reg
                 ? palette(rd_lo_reg, color_zero_reg, color_one_reg, color_two_reg) : 24'h0;
    end

    wpps_blend u_blend_red
    (
        .upper  (up_color[23:16]),
        .lower  (lo_color[23:16]),
        .mix    (s2_mix_reg),
        .result (red)
    );

    wpps_blend u_blend_green
    (
        .upper  (up_color[15:8]),
        .lower  (lo_color[15:8]),
        .mix    (s2_mix_reg),
        .result (green)
    );

    wpps_blend u_blend_blue
    (
        .upper  (up_color[7:0]),
        .lower  (lo_color[7:0]),
        .mix    (s2_mix_reg),
        .result (blue)
    );

    // Output register
    logic [OUT_TDATA_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en_out)
            out_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_out && s2_v_reg)
            out_data_reg <= {1'b0, s2_line_reg, s2_col_reg, blue, green, red};
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: hdl/wpps_checker.sv
// Port-level checks for the waving pattern pixel shader, bound to its top level.
`default_nettype none

module wpps_checker
#(
    parameter int WIDTH  = wpps_pkg::WIDTH_DEF,
    parameter int HEIGHT = wpps_pkg::HEIGHT_DEF
)
(
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [wpps_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import wpps_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // No result while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    // Result position lies on the matrix
    a_on_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[26:24]) < WIDTH)
                       && (32'(m_axis_tdata[30:27]) < HEIGHT))
        else $error("result position off the matrix");

    // Input stalls only when the output is full and held
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

endmodule

bind waving_pattern_pixel_shader_top wpps_checker
#(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
)
u_wpps_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
